### rtl/cdfu_pkg.sv
// ----------------------------------------------------------------------------
// cdfu_pkg: shared types and constants for cube face selection
// Component and fraction widths, face codes and the divider pipeline word.
// ----------------------------------------------------------------------------
package cdfu_pkg;

    localparam int COMPONENT_BITS = 16;
    localparam int FRACTION_BITS  = 16;

    // Packed stream widths, rounded up to whole bytes
    localparam int IN_FIELD_W  = 3 * COMPONENT_BITS;
    localparam int IN_DATA_W   = ((IN_FIELD_W + 7) / 8) * 8;
    localparam int COORD_W     = FRACTION_BITS + 1;
    localparam int OUT_FIELD_W = 3 + 2 * COORD_W;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

    // Cube faces in output order
    typedef enum logic [2:0] {
        FACE_POS_X = 3'd0,
        FACE_NEG_X = 3'd1,
        FACE_POS_Y = 3'd2,
        FACE_NEG_Y = 3'd3,
        FACE_POS_Z = 3'd4,
        FACE_NEG_Z = 3'd5
    } t_face;

    // Word carried through the fraction divider stages
    typedef struct packed {
        t_face                     face;
        logic                      zero;
        logic [COMPONENT_BITS:0]   den;
        logic [COMPONENT_BITS:0]   rem_u;
        logic [COMPONENT_BITS:0]   rem_v;
        logic [FRACTION_BITS:0]    quo_u;
        logic [FRACTION_BITS:0]    quo_v;
    } t_div_word;

    // One restoring step: shift the remainder, compare, subtract.
    // Returns {quotient bit, new remainder}.
    function automatic logic [COMPONENT_BITS+1:0] div_step(
        input logic [COMPONENT_BITS:0] rem,
        input logic [COMPONENT_BITS:0] den
    );
        logic [COMPONENT_BITS+1:0] shifted;
        logic [COMPONENT_BITS+1:0] diff;
        logic                      ge;
        shifted = {rem, 1'b0};
        diff    = shifted - {1'b0, den};
        ge      = (shifted >= {1'b0, den});
        return {ge, (ge ? diff[COMPONENT_BITS:0] : shifted[COMPONENT_BITS:0])};
    endfunction

endpackage

### rtl/cdfu_select.sv
// ----------------------------------------------------------------------------
// cdfu_select: major axis and face selection front end
// Three stages: magnitudes, major axis with numerators, first quotient bit.
// ----------------------------------------------------------------------------
module cdfu_select (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_valid,
    output logic                                          o_ready,
    input  logic signed [cdfu_pkg::COMPONENT_BITS-1:0]    i_dir_x,
    input  logic signed [cdfu_pkg::COMPONENT_BITS-1:0]    i_dir_y,
    input  logic signed [cdfu_pkg::COMPONENT_BITS-1:0]    i_dir_z,
    output logic                                          o_valid,
    input  logic                                          i_ready,
    output cdfu_pkg::t_div_word                           o_word
);
    import cdfu_pkg::*;

    localparam int CB = COMPONENT_BITS;
    localparam int FB = FRACTION_BITS;

    // Stage A registers
    logic          r_va;
    logic [CB-1:0] r_x, r_y, r_z;
    logic [CB-1:0] r_ax, r_ay, r_az;
    // Stage B registers
    logic          r_vb;
    t_face         r_face_b;
    logic          r_zero_b;
    logic [CB:0]   r_num_u, r_num_v, r_den_b;
    // Stage C registers
    logic          r_vc;
    t_div_word     r_word_c;

    logic rdy_a, rdy_b, rdy_c;

    // Stage A next values
    logic [CB-1:0] n_ax, n_ay, n_az;
    // Stage B next values
    logic          n_zero;
    logic [CB-1:0] m_sel;
    t_face         n_face;
    logic [CB:0]   ext_x, ext_y, ext_z;
    logic [CB:0]   cu, cv;
    logic [CB+1:0] sum_u, sum_v;
    logic [CB:0]   n_num_u, n_num_v, n_den;
    // Stage C next values
    t_div_word     n_word;
    logic          q0_u, q0_v;

    assign rdy_c   = !r_vc || i_ready;
    assign rdy_b   = !r_vb || rdy_c;
    assign rdy_a   = !r_va || rdy_b;
    assign o_ready = rdy_a;
    assign o_valid = r_vc;
    assign o_word  = r_word_c;

    // Take magnitudes; the most negative value maps to its exact magnitude
    always_comb begin
        n_ax = i_dir_x[CB-1] ? (~i_dir_x + CB'(1)) : i_dir_x;
        n_ay = i_dir_y[CB-1] ? (~i_dir_y + CB'(1)) : i_dir_y;
        n_az = i_dir_z[CB-1] ? (~i_dir_z + CB'(1)) : i_dir_z;
    end

    // Pick the major axis (ties to X, then Y) and form numerators
    always_comb begin
        ext_x  = {r_x[CB-1], r_x};
        ext_y  = {r_y[CB-1], r_y};
        ext_z  = {r_z[CB-1], r_z};
        n_zero = (r_ax == '0) && (r_ay == '0) && (r_az == '0);
        if ((r_ax >= r_ay) && (r_ax >= r_az)) begin
            m_sel = r_ax;
            cv    = ext_y;
            if (!r_x[CB-1]) begin
                n_face = FACE_POS_X;
                cu     = -ext_z;
            end else begin
                n_face = FACE_NEG_X;
                cu     = ext_z;
            end
        end else if (r_ay >= r_az) begin
            m_sel = r_ay;
            cu    = ext_x;
            if (!r_y[CB-1]) begin
                n_face = FACE_POS_Y;
                cv     = -ext_z;
            end else begin
                n_face = FACE_NEG_Y;
                cv     = ext_z;
            end
        end else begin
            m_sel = r_az;
            cv    = ext_y;
            if (!r_z[CB-1]) begin
                n_face = FACE_POS_Z;
                cu     = ext_x;
            end else begin
                n_face = FACE_NEG_Z;
                cu     = -ext_x;
            end
        end
        // Zero vector: one over two gives exactly one half
        if (n_zero) begin
            m_sel = CB'(1);
        end
        sum_u   = {2'b00, m_sel} + {cu[CB], cu};
        sum_v   = {2'b00, m_sel} + {cv[CB], cv};
        n_num_u = sum_u[CB:0];
        n_num_v = sum_v[CB:0];
        n_den   = {m_sel, 1'b0};
    end

    // Integer quotient bit: only set when numerator equals the divisor
    always_comb begin
        q0_u         = (r_num_u >= r_den_b);
        q0_v         = (r_num_v >= r_den_b);
        n_word.face  = r_face_b;
        n_word.zero  = r_zero_b;
        n_word.den   = r_den_b;
        n_word.rem_u = q0_u ? (r_num_u - r_den_b) : r_num_u;
        n_word.rem_v = q0_v ? (r_num_v - r_den_b) : r_num_v;
        n_word.quo_u = {{FB{1'b0}}, q0_u};
        n_word.quo_v = {{FB{1'b0}}, q0_v};
    end

    // Advance valid bits per stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (rdy_a) r_va <= i_valid;
            if (rdy_b) r_vb <= r_va;
            if (rdy_c) r_vc <= r_vb;
        end
    end

    // Hold payload while a stage is stalled
    always_ff @(posedge i_clk) begin
        if (rdy_a) begin
            r_x  <= i_dir_x;
            r_y  <= i_dir_y;
            r_z  <= i_dir_z;
            r_ax <= n_ax;
            r_ay <= n_ay;
            r_az <= n_az;
        end
        if (rdy_b) begin
            r_face_b <= n_face;
            r_zero_b <= n_zero;
            r_num_u  <= n_num_u;
            r_num_v  <= n_num_v;
            r_den_b  <= n_den;
        end
        if (rdy_c) begin
            r_word_c <= n_word;
        end
    end

endmodule

### rtl/cdfu_div_stage.sv
// ----------------------------------------------------------------------------
// cdfu_div_stage: one fraction bit of the pipelined restoring divider
// Develops one quotient bit for both face coordinates per stage.
// ----------------------------------------------------------------------------
module cdfu_div_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  cdfu_pkg::t_div_word  i_word,
    output logic                 o_valid,
    input  logic                 i_ready,
    output cdfu_pkg::t_div_word  o_word
);
    import cdfu_pkg::*;

    localparam int CB = COMPONENT_BITS;
    localparam int FB = FRACTION_BITS;

    logic          r_valid;
    t_div_word     r_word;
    t_div_word     n_word;
    logic          stage_rdy;
    logic [CB+1:0] step_u, step_v;

    assign stage_rdy = !r_valid || i_ready;
    assign o_ready   = stage_rdy;
    assign o_valid   = r_valid;
    assign o_word    = r_word;

    // Shift in the next quotient bit of each coordinate
    always_comb begin
        step_u       = div_step(i_word.rem_u, i_word.den);
        step_v       = div_step(i_word.rem_v, i_word.den);
        n_word       = i_word;
        n_word.rem_u = step_u[CB:0];
        n_word.rem_v = step_v[CB:0];
        n_word.quo_u = {i_word.quo_u[FB-1:0], step_u[CB+1]};
        n_word.quo_v = {i_word.quo_v[FB-1:0], step_v[CB+1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (stage_rdy) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_rdy) begin
            r_word <= n_word;
        end
    end

endmodule

### rtl/cube_direction_to_face_uv_top.sv
// ----------------------------------------------------------------------------
// cube_direction_to_face_uv_top: cube map face and (u, v) from a direction
// Front end picks the face; a bit-per-stage divider forms both coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis carries one direction word per handshake: three
//   signed components. Master channel m_axis returns one word per input:
//   face code and the two face coordinates in unsigned fixed point with
//   FRACTION_BITS fraction bits (1.0 is 1 << FRACTION_BITS), plus a tuser
//   flag marking a zero vector (face +X, u = v = one half).
//   Three front-end stages, then one divider stage per fraction bit.
//   Throughput is one word per cycle while m_axis_tready is high; the divider
//   is fully pipelined, with one restoring subtract per stage per coordinate.
//   Every stage has its own valid bit and takes new data when it is empty
//   or its successor moves, so bubbles close up under backpressure.
//   When m_axis_tready is low the last stage holds its word; s_axis_tready
//   falls only once every stage is full. Synchronous active-low reset clears
//   all valid bits; nothing else needs initialization.
// ----------------------------------------------------------------------------
module cube_direction_to_face_uv_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: dir_x, dir_y, dir_z (lowest bits first)
    input  logic [cdfu_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: face, coord_u, coord_v (lowest bits first), zero padded
    output logic [cdfu_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // tuser: zero_vector
    output logic                               m_axis_tuser
);
    import cdfu_pkg::*;

    localparam int CB = COMPONENT_BITS;
    localparam int FB = FRACTION_BITS;
    localparam logic [FB:0] COORD_ONE  = {1'b1, {FB{1'b0}}};
    localparam logic [FB:0] COORD_HALF = {2'b01, {(FB-1){1'b0}}};

    t_div_word w_word  [FB+1];
    logic      w_valid [FB+1];
    logic      w_ready [FB+1];

    logic [CB-1:0] in_x, in_y, in_z;

    assign in_x = s_axis_tdata[CB-1:0];
    assign in_y = s_axis_tdata[2*CB-1:CB];
    assign in_z = s_axis_tdata[3*CB-1:2*CB];

    // Front end: magnitudes, face, numerators, integer quotient bit
    cdfu_select u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_dir_x (in_x),
        .i_dir_y (in_y),
        .i_dir_z (in_z),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_word  (w_word[0])
    );

    // Divider chain: one fraction bit per stage
    for (genvar k = 0; k < FB; k++) begin : g_div
        cdfu_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_word  (w_word[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_word  (w_word[k+1])
        );
    end

    // Drive the master channel from the last divider stage
    assign w_ready[FB]   = m_axis_tready;
    assign m_axis_tvalid = w_valid[FB];
    assign m_axis_tuser  = w_word[FB].zero;
    assign m_axis_tdata  = {{(OUT_DATA_W-OUT_FIELD_W){1'b0}},
                            w_word[FB].quo_v, w_word[FB].quo_u, w_word[FB].face};

    // Zero vector words carry the defaulted face and coordinates
    a_zero_default: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            (w_word[FB].face == FACE_POS_X) && (w_word[FB].quo_u == COORD_HALF)
            && (w_word[FB].quo_v == COORD_HALF))
        else $error("zero vector result not defaulted");

    // Coordinates never exceed 1.0
    a_coord_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_word[FB].quo_u <= COORD_ONE)
            && (w_word[FB].quo_v <= COORD_ONE))
        else $error("face coordinate above one");

    // Divider remainders stay below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_word[FB].rem_u < w_word[FB].den)
            && (w_word[FB].rem_v < w_word[FB].den))
        else $error("divider remainder out of range");

    // Face code is one of the six faces
    a_face_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[0] |-> (w_word[0].face == FACE_POS_X) || (w_word[0].face == FACE_NEG_X)
            || (w_word[0].face == FACE_POS_Y) || (w_word[0].face == FACE_NEG_Y)
            || (w_word[0].face == FACE_POS_Z) || (w_word[0].face == FACE_NEG_Z))
        else $error("invalid face code");

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stream-level test of cube_direction_to_face_uv_top
// Drives signed direction words into s_axis and scores every m_axis word
// against a local cube face and (u, v) predictor. The sender works in bursts
// and the receiver stalls, with one long hold-off that backs the pipe up.
// ----------------------------------------------------------------------------
module tb_top;
    import cdfu_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int PIPE_DEPTH  = 3 + FRACTION_BITS;
    localparam int RANDOM_DIRS = 1000;

    typedef logic signed [COMPONENT_BITS-1:0] comp_t;
    typedef logic [COORD_W-1:0]               coord_t;

    // One predicted result word
    typedef struct {
        t_face  face;
        coord_t coord_u;
        coord_t coord_v;
        logic   zero_vector;
    } face_uv_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // tdata: dir_x, dir_y, dir_z (lowest bits first)
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // tdata: face, coord_u, coord_v (lowest bits first), zero padded
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // tuser: zero_vector
    logic                  m_axis_tuser;

    face_uv_t pending_faces[$];
    int       n_sent = 0;
    int       n_checked = 0;
    int       n_errors = 0;
    int       n_input_stalls = 0;
    int       burst_left = 0;
    bit       sender_gaps = 1'b1;
    int       hold_request = 0;

    cube_direction_to_face_uv_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock: 10 time units per period
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Face coordinate (m + c) / 2m in fixed point, floor, clamped to [0, 1.0]
    function automatic coord_t face_coord_frac(longint m, longint c);
        longint num;
        longint q;
        num = m + c;
        if (num < 0) num = 0;
        if (num > 2 * m) num = 2 * m;
        q = (num << FRACTION_BITS) / (2 * m);
        if (q > (longint'(1) << FRACTION_BITS)) q = longint'(1) << FRACTION_BITS;
        return coord_t'(q);
    endfunction

    // Pick the major axis (ties to X, then Y) and form both face coordinates
    function automatic face_uv_t predict_face_uv(comp_t dx, comp_t dy, comp_t dz);
        face_uv_t r;
        longint   x, y, z, ax, ay, az, m, cu, cv;
        x  = dx;
        y  = dy;
        z  = dz;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        az = (z < 0) ? -z : z;
        r.zero_vector = 1'b0;
        if (ax == 0 && ay == 0 && az == 0) begin
            r.face        = FACE_POS_X;
            r.coord_u     = coord_t'(1) << (FRACTION_BITS - 1);
            r.coord_v     = coord_t'(1) << (FRACTION_BITS - 1);
            r.zero_vector = 1'b1;
            return r;
        end
        if (ax >= ay && ax >= az) begin
            m = ax;
            if (x >= 0) begin
                r.face = FACE_POS_X; cu = -z; cv = y;
            end else begin
                r.face = FACE_NEG_X; cu = z;  cv = y;
            end
        end else if (ay >= az) begin
            m = ay;
            if (y >= 0) begin
                r.face = FACE_POS_Y; cu = x; cv = -z;
            end else begin
                r.face = FACE_NEG_Y; cu = x; cv = z;
            end
        end else begin
            m = az;
            if (z >= 0) begin
                r.face = FACE_POS_Z; cu = x;  cv = y;
            end else begin
                r.face = FACE_NEG_Z; cu = -x; cv = y;
            end
        end
        r.coord_u = face_coord_frac(m, cu);
        r.coord_v = face_coord_frac(m, cv);
        return r;
    endfunction

    // Offer one direction word and hold it until the block takes it
    task automatic send_direction(comp_t dx, comp_t dy, comp_t dz);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {dz, dy, dx};
        do begin
            @(posedge i_clk);
            if (s_axis_tvalid && !s_axis_tready) n_input_stalls++;
        end while (!(s_axis_tvalid && s_axis_tready));
        pending_faces = {pending_faces, predict_face_uv(dx, dy, dz)};
        n_sent++;
    endtask

    // Send within the burst pattern: idle for a random gap when a burst ends
    task automatic offer_direction(comp_t dx, comp_t dy, comp_t dz);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (sender_gaps && gap > 0) begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= IN_DATA_W'({$urandom, $urandom});
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        burst_left--;
        send_direction(dx, dy, dz);
    endtask

    // Offer a direction given as plain integers
    task automatic offer_ints(int dx, int dy, int dz);
        offer_direction(comp_t'(dx), comp_t'(dy), comp_t'(dz));
    endtask

    // Zero vector, extremes, ties, every face and the clamp ends of u and v
    task automatic test_directed();
        offer_ints(0, 0, 0);
        offer_ints(1, 0, 0);
        offer_ints(-1, -1, -1);
        offer_ints(32767, 0, 0);
        offer_ints(-32768, 0, 0);
        offer_ints(0, 32767, -32768);
        offer_ints(0, -32768, 32767);
        offer_ints(0, 0, -32768);
        offer_ints(12, -5, 300);
        offer_ints(5, 5, 5);
        offer_ints(-5, 5, 0);
        offer_ints(0, 7, -7);
        offer_ints(0, -7, 7);
        offer_ints(-32768, 32767, -32768);
        offer_ints(32767, -32768, 32767);
        offer_ints(100, -100, 100);
        offer_ints(100, 100, -100);
        offer_ints(-32768, -32768, -32768);
        offer_ints(3, 1, 0);
        offer_ints(-7, 3, -2);
        offer_ints(2, -9, 1);
        offer_ints(-32767, 32767, 32767);
    endtask

    // Random directions, weighted toward ties, small values and extremes
    task automatic test_random(int count);
        comp_t corners[6] = '{-32768, -32767, -1, 0, 1, 32767};
        int    a[3];
        int    m, rot;
        for (int i = 0; i < count; i++) begin
            // run a stretch with no sender gaps
            sender_gaps = !(i >= 300 && i < 500);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    a[0] = $urandom; a[1] = $urandom; a[2] = $urandom;
                end
                4, 5: begin
                    for (int k = 0; k < 3; k++) a[k] = int'($urandom_range(0, 6)) - 3;
                end
                6: begin
                    m    = $urandom_range(1, 32768);
                    a[0] = $urandom_range(0, 1) ? m : -m;
                    a[1] = ($urandom_range(0, 1) ? m : -m) + int'($urandom_range(0, 2)) - 1;
                    a[2] = int'($urandom_range(0, 2 * m)) - m;
                end
                7: begin
                    for (int k = 0; k < 3; k++) a[k] = corners[$urandom_range(0, 5)];
                end
                8: begin
                    m    = $urandom_range(1, 32768);
                    a[0] = $urandom_range(0, 1) ? m : -m;
                    a[1] = int'($urandom_range(0, 2 * m)) - m;
                    a[2] = int'($urandom_range(0, 2 * m)) - m;
                end
                default: begin
                    a[0] = $urandom_range(0, 1) ? 1 : -1;
                    a[1] = 0;
                    a[2] = $urandom_range(0, 1);
                end
            endcase
            rot = $urandom_range(0, 2);
            offer_direction(comp_t'(a[rot]), comp_t'(a[(rot + 1) % 3]),
                            comp_t'(a[(rot + 2) % 3]));
        end
        sender_gaps = 1'b1;
    endtask

    // Hold the receiver off while the sender keeps offering, so the pipe fills
    task automatic test_backpressure();
        hold_request = 400;
        for (int i = 0; i < 80; i++)
            send_direction(comp_t'($urandom), comp_t'($urandom), comp_t'($urandom));
    endtask

    // Receiver: long hold-offs on request, otherwise its own stall pattern
    int hold_left = 0;
    int pattern_left = 0;
    int rx_mode = 0;
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                rx_mode      = $urandom_range(0, 3);
                pattern_left = $urandom_range(16, 128);
            end
            pattern_left--;
            case (rx_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= pattern_left[0];
            endcase
        end
    end

    // Score each result word against the oldest prediction
    always @(posedge i_clk) begin
        face_uv_t want;
        logic [2:0] got_face;
        coord_t     got_u, got_v;
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            got_face = m_axis_tdata[2:0];
            got_u    = m_axis_tdata[3 +: COORD_W];
            got_v    = m_axis_tdata[3 + COORD_W +: COORD_W];
            if (pending_faces.size() == 0) begin
                $error("result word with no direction outstanding");
                n_errors++;
            end else begin
                want = pending_faces.pop_front();
                n_checked++;
                if (got_face !== want.face) begin
                    $error("face: expected %0d, actual %0d", want.face, got_face);
                    n_errors++;
                end
                if (got_u !== want.coord_u) begin
                    $error("coord_u: expected %0d, actual %0d", want.coord_u, got_u);
                    n_errors++;
                end
                if (got_v !== want.coord_v) begin
                    $error("coord_v: expected %0d, actual %0d", want.coord_v, got_v);
                    n_errors++;
                end
                if (m_axis_tuser !== want.zero_vector) begin
                    $error("zero_vector: expected %0d, actual %0d",
                           want.zero_vector, m_axis_tuser);
                    n_errors++;
                end
            end
        end
    end

    // Main sequence
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(RANDOM_DIRS);
        test_backpressure();
        test_random(100);
        s_axis_tvalid <= 1'b0;
        // drain the pipe, then watch for stray words
        while (pending_faces.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 10) @(posedge i_clk);
        $display("tb: %0d directions sent, %0d result words checked", n_sent, n_checked);
        $display("tb: faces, ties, zero vectors, extremes; input stalled %0d cycles",
                 n_input_stalls);
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

### files.f
rtl/cdfu_pkg.sv
rtl/cdfu_select.sv
rtl/cdfu_div_stage.sv
rtl/cube_direction_to_face_uv_top.sv
sim/tb_top.sv
